/* design/scsr_pkg.sv */
// shared constants and types for the speed constraint stream repair block
package scsr_pkg;

    localparam int WINDOW_POINTS = 16;
    localparam int IDX_W = $clog2(WINDOW_POINTS);
    localparam int CNT_W = $clog2(WINDOW_POINTS + 1);
    localparam int MAX_CAND = 2 * WINDOW_POINTS - 1;
    localparam int CAND_W = $clog2(MAX_CAND + 1);
    localparam int CIDX_W = $clog2(MAX_CAND);

    localparam logic [1:0] REG_MIN_SPEED = 2'd0;
    localparam logic [1:0] REG_MAX_SPEED = 2'd1;
    localparam logic [1:0] REG_WINDOW = 2'd2;

    typedef struct packed {
        logic [31:0] time_val;
        logic signed [31:0] value;
        logic end_of_stream;
    } sample_t;

    typedef struct packed {
        logic [31:0] out_time;
        logic signed [31:0] repaired_value;
        logic forced_early;
        logic last_of_run;
    } result_t;

    // saturate a 34-bit signed sum to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
        logic signed [31:0] r;
        if (x > 34'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -34'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

/* design/scsr_stream_if.sv */
// valid/ready stream channel
interface scsr_stream_if #(parameter int W = 1);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/scsr_ram.sv */
// generic ram with one write port and one registered read port
module scsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic clk,
    input  logic we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

/* design/scsr_project.sv */
// multicycle projection: base + round(speed*dt/256), saturated
module scsr_project import scsr_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic signed [31:0] base,
    input  logic signed [31:0] speed,
    input  logic signed [32:0] dt,
    output logic done,
    output logic signed [31:0] result
);
    logic [1:0] phase_reg;
    logic signed [64:0] prod_reg;
    logic signed [31:0] base_reg;
    logic signed [65:0] q_wide;
    logic signed [33:0] sum;

    // arithmetic shift floors, matching round half up after the +128
    assign q_wide = ($signed({prod_reg[64], prod_reg}) + 66'sd128) >>> 8;

    always_comb
    begin
        if (q_wide > 66'sd4294967295)
            sum = 34'sd4294967295;
        else if (q_wide < -66'sd4294967296)
            sum = -34'sd4294967296;
        else
            sum = q_wide[33:0] + {{2{base_reg[31]}}, base_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            done <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (phase_reg)
                2'd0:
                begin
                    if (start)
                    begin
                        prod_reg <= 65'(speed * dt);
                        base_reg <= base;
                        phase_reg <= 2'd1;
                    end
                end
                2'd1:
                begin
                    result <= sat32(sum);
                    done <= 1'b1;
                    phase_reg <= 2'd0;
                end
                default: phase_reg <= 2'd0;
            endcase
        end
    end
endmodule

/* design/speed_constraint_stream_repair.sv */
// speed constraint stream repair: buffering, candidate build and median select
// each repair builds up to 31 candidates (two projections per follower)
// and finds the median by counting ranks with one shared comparator pair;
// one item at a time, and the block stalls while its output is not taken;
// reset empties the buffer and starts a new stream, no clearing pass
module speed_constraint_stream_repair import scsr_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    scsr_stream_if.sink in_ch,
    scsr_stream_if.source out_ch,
    input  logic cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [31:0] cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_RD0, S_RD0W, S_FOLRD, S_FOLW, S_PROJ, S_PROJW,
        S_RANK, S_BOUND, S_BOUNDW, S_EMIT, S_SHIFT, S_SHIFTW, S_APPEND
    } state_t;

    state_t state_reg;
    logic signed [31:0] min_speed_reg, max_speed_reg;
    logic [31:0] window_reg;
    sample_t in_reg;
    logic [CNT_W-1:0] count_reg;
    logic signed [31:0] prev_val_reg;
    logic [31:0] prev_time_reg;
    logic first_reg;
    logic appended_reg, forced_reg, any_reg;
    logic [31:0] tp_reg;
    logic signed [31:0] vp_reg;
    logic [CNT_W-1:0] fol_reg;
    logic [31:0] ft_reg;
    logic signed [31:0] fv_reg;
    logic proj_hi_reg;
    logic [CAND_W-1:0] ncand_reg;
    logic [CIDX_W-1:0] ci_reg, cj_reg;
    logic [CAND_W-1:0] less_reg, leq_reg;
    logic signed [31:0] med_reg, lo_reg;
    logic out_valid_reg;
    result_t out_reg;
    logic signed [31:0] cand [MAX_CAND];

    // pending store
    logic we;
    logic [IDX_W-1:0] waddr, raddr;
    logic [63:0] wdata, rdata;
    scsr_ram #(.WIDTH(64), .DEPTH(WINDOW_POINTS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr),
        .rdata(rdata)
    );

    // shared projection unit
    logic pj_start, pj_done;
    logic signed [31:0] pj_base, pj_speed, pj_res;
    logic signed [32:0] pj_dt;
    scsr_project u_proj (
        .clk(clk), .rst_n(rst_n), .start(pj_start), .base(pj_base),
        .speed(pj_speed), .dt(pj_dt), .done(pj_done), .result(pj_res)
    );

    logic [32:0] tp_win;
    logic signed [31:0] ca, cb;
    logic rank_hit;
    assign tp_win = {1'b0, tp_reg} + {1'b0, window_reg};
    assign ca = cand[ci_reg];
    assign cb = cand[cj_reg];
    // median is the candidate with less < n/2+1 <= leq
    assign rank_hit = (less_reg <= CAND_W'(ncand_reg >> 1))
                   && (leq_reg > CAND_W'(ncand_reg >> 1));

    assign in_ch.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_reg;

    always_comb
    begin
        we = 1'b0;
        waddr = '0;
        wdata = {in_reg.time_val, in_reg.value};
        raddr = '0;
        pj_start = 1'b0;
        pj_base = fv_reg;
        pj_speed = proj_hi_reg ? max_speed_reg : min_speed_reg;
        pj_dt = $signed({1'b0, tp_reg}) - $signed({1'b0, ft_reg});
        case (state_reg)
            S_FOLRD: raddr = IDX_W'(fol_reg);
            S_PROJ: pj_start = 1'b1;
            S_BOUND:
            begin
                pj_start = 1'b1;
                pj_base = prev_val_reg;
                pj_dt = $signed({1'b0, tp_reg}) - $signed({1'b0, prev_time_reg});
            end
            S_SHIFT: raddr = IDX_W'(fol_reg);
            S_SHIFTW:
            begin
                we = 1'b1;
                waddr = IDX_W'(fol_reg - CNT_W'(1));
                wdata = rdata;
            end
            S_APPEND:
            begin
                we = 1'b1;
                waddr = IDX_W'(count_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD0W)
            cand[0] <= rdata[31:0];
        if (state_reg == S_PROJW && pj_done)
            cand[CIDX_W'(ncand_reg)] <= pj_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            min_speed_reg <= '0;
            max_speed_reg <= '0;
            window_reg <= '0;
            count_reg <= '0;
            prev_val_reg <= '0;
            prev_time_reg <= '0;
            first_reg <= 1'b1;
            out_valid_reg <= 1'b0;
            appended_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MIN_SPEED: min_speed_reg <= cfg_data;
                    REG_MAX_SPEED: max_speed_reg <= cfg_data;
                    REG_WINDOW: window_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        in_reg <= in_ch.data;
                        appended_reg <= 1'b0;
                        forced_reg <= 1'b0;
                        any_reg <= 1'b0;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    // decide the next repair or finish the item
                    if (out_valid_reg)
                        state_reg <= S_CHECK;
                    else if (!appended_reg)
                    begin
                        // after a forced repair the sample goes straight in
                        if (count_reg != '0 && !forced_reg)
                            state_reg <= S_RD0;
                        else
                            state_reg <= S_APPEND;
                    end
                    else if (in_reg.end_of_stream && count_reg != '0)
                    begin
                        forced_reg <= 1'b0;
                        state_reg <= S_RD0;
                    end
                    else
                    begin
                        if (in_reg.end_of_stream)
                        begin
                            first_reg <= 1'b1;
                            prev_val_reg <= '0;
                            prev_time_reg <= '0;
                        end
                        if (any_reg)
                        begin
                            out_reg.last_of_run <= 1'b1;
                            out_valid_reg <= 1'b1;
                            any_reg <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_RD0: state_reg <= S_RD0W;
                S_RD0W:
                begin
                    tp_reg <= rdata[63:32];
                    vp_reg <= rdata[31:0];
                    // expiry test happens before append only
                    if (!appended_reg)
                    begin
                        if ({1'b0, in_reg.time_val} > {1'b0, rdata[63:32]}
                                + {1'b0, window_reg})
                            state_reg <= S_FOLRD;
                        else if (count_reg == CNT_W'(WINDOW_POINTS))
                        begin
                            forced_reg <= 1'b1;
                            state_reg <= S_FOLRD;
                        end
                        else
                            state_reg <= S_APPEND;
                    end
                    else
                        state_reg <= S_FOLRD;
                    fol_reg <= CNT_W'(1);
                    ncand_reg <= CAND_W'(1);
                end
                S_FOLRD:
                begin
                    if (fol_reg >= count_reg)
                    begin
                        ci_reg <= '0;
                        cj_reg <= '0;
                        less_reg <= '0;
                        leq_reg <= '0;
                        state_reg <= S_RANK;
                    end
                    else
                        state_reg <= S_FOLW;
                end
                S_FOLW:
                begin
                    if ({1'b0, rdata[63:32]} > tp_win)
                    begin
                        ci_reg <= '0;
                        cj_reg <= '0;
                        less_reg <= '0;
                        leq_reg <= '0;
                        state_reg <= S_RANK;
                    end
                    else
                    begin
                        ft_reg <= rdata[63:32];
                        fv_reg <= rdata[31:0];
                        proj_hi_reg <= 1'b0;
                        state_reg <= S_PROJ;
                    end
                end
                S_PROJ: state_reg <= S_PROJW;
                S_PROJW:
                begin
                    if (pj_done)
                    begin
                        ncand_reg <= ncand_reg + CAND_W'(1);
                        if (!proj_hi_reg)
                        begin
                            proj_hi_reg <= 1'b1;
                            state_reg <= S_PROJ;
                        end
                        else
                        begin
                            fol_reg <= fol_reg + CNT_W'(1);
                            state_reg <= S_FOLRD;
                        end
                    end
                end
                S_RANK:
                begin
                    // count how many candidates are below and not above cand[i]
                    if (CAND_W'(cj_reg) < ncand_reg)
                    begin
                        if (cb < ca)
                            less_reg <= less_reg + CAND_W'(1);
                        if (cb <= ca)
                            leq_reg <= leq_reg + CAND_W'(1);
                        cj_reg <= cj_reg + CIDX_W'(1);
                    end
                    else if (rank_hit)
                    begin
                        med_reg <= ca;
                        proj_hi_reg <= 1'b0;
                        state_reg <= first_reg ? S_EMIT : S_BOUND;
                    end
                    else
                    begin
                        ci_reg <= ci_reg + CIDX_W'(1);
                        cj_reg <= '0;
                        less_reg <= '0;
                        leq_reg <= '0;
                    end
                end
                S_BOUND: state_reg <= S_BOUNDW;
                S_BOUNDW:
                begin
                    if (pj_done)
                    begin
                        if (!proj_hi_reg)
                        begin
                            lo_reg <= pj_res;
                            proj_hi_reg <= 1'b1;
                            state_reg <= S_BOUND;
                        end
                        else
                        begin
                            if (pj_res < med_reg)
                                med_reg <= pj_res;
                            else if (lo_reg > med_reg)
                                med_reg <= lo_reg;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_EMIT:
                begin
                    // hold previous result in out_reg until it is taken
                    if (out_valid_reg)
                        state_reg <= S_EMIT;
                    else if (any_reg)
                    begin
                        // the held result is not the last one of the item
                        out_valid_reg <= 1'b1;
                        any_reg <= 1'b0;
                    end
                    else
                    begin
                        out_reg.out_time <= tp_reg;
                        out_reg.repaired_value <= first_reg ? vp_reg : med_reg;
                        out_reg.forced_early <= forced_reg;
                        out_reg.last_of_run <= 1'b0;
                        prev_val_reg <= first_reg ? vp_reg : med_reg;
                        prev_time_reg <= tp_reg;
                        first_reg <= 1'b0;
                        any_reg <= 1'b1;
                        fol_reg <= CNT_W'(1);
                        state_reg <= S_SHIFT;
                    end
                end
                S_SHIFT:
                begin
                    if (fol_reg >= count_reg)
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= S_CHECK;
                    end
                    else
                        state_reg <= S_SHIFTW;
                end
                S_SHIFTW:
                begin
                    fol_reg <= fol_reg + CNT_W'(1);
                    state_reg <= S_SHIFT;
                end
                S_APPEND:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    appended_reg <= 1'b1;
                    state_reg <= S_CHECK;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
